// File: rtl/core/ugd_pkg.sv
// Shared widths, error codes and saturation limits for the grid derivative block.
`default_nettype none
package ugd_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int FRAC_BITS = 16;
    localparam int TOL_W     = 16;
    localparam int ERR_W     = 2;

    localparam int STEP_W = SAMPLE_W + 1;          // exact voltage difference
    localparam int DEV_W  = SAMPLE_W + 2;          // step minus grid step
    localparam int CMP_W  = SAMPLE_W + 3;          // deviation against +/- tolerance
    localparam int NUM_W  = SAMPLE_W + 3;          // signed three-term numerator
    localparam int MAG_W  = SAMPLE_W + 2;          // numerator and divisor magnitude
    localparam int DVD_W  = MAG_W + FRAC_BITS;     // scaled dividend
    localparam int Q_W    = SAMPLE_W + 1;          // quotient window before saturation
    localparam int CNT_W  = $clog2(DVD_W + 1);

    localparam logic [Q_W-1:0] SAT_POS = {2'b00, {(SAMPLE_W-1){1'b1}}};
    localparam logic [Q_W-1:0] SAT_NEG = {2'b01, {(SAMPLE_W-1){1'b0}}};
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 2'd0,
        ERR_FEW      = 2'd1,
        ERR_ZERO     = 2'd2,
        ERR_NONUNI   = 2'd3
    } t_err;

endpackage
`default_nettype wire

// File: rtl/core/uniform_grid_derivative.sv
// Top level: streaming dI/dV on a uniform grid with a bit-serial shared divider.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready   voltage, current, sequence_end
//  output    out        o_out_valid / i_out_ready derivative, error_code, run_last
//  config    in         i_cfg_wr_en               i_cfg_wr_data (spacing tolerance)
//
// Each derivative passes setup, magnitude, one restoring-divide step per dividend
// bit and saturate in the single divider, which makes one quotient bit per cycle;
// an item makes up to three of them in turn.
// Synchronous active-low reset clears sequence state; tolerance resets to 1.
// A full output register stalls the sequencer until the request is taken.
`default_nettype none
module uniform_grid_derivative
    import ugd_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [TOL_W-1:0]           i_cfg_wr_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_voltage_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_current_sample,
    input  wire logic                       i_sequence_end,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0]      o_derivative,
    output logic [ERR_W-1:0]                o_error_code,
    output logic                            o_run_last
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_MAG   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [TOL_W-1:0]           r_tol;
    logic signed [SAMPLE_W-1:0] r_v, n_v, r_c, n_c;
    logic                       r_end, n_end;
    logic signed [STEP_W-1:0]   r_step, n_step;

    logic signed [SAMPLE_W-1:0] r_hist0, n_hist0, r_hist1, n_hist1, r_prev, n_prev;
    logic signed [STEP_W-1:0]   r_grid, n_grid;
    logic [1:0]                 r_pts, n_pts;
    logic                       r_err, n_err;

    logic r_job_first, n_job_first, r_job_center, n_job_center, r_job_last, n_job_last;
    logic r_cur_last, n_cur_last;

    logic signed [NUM_W-1:0] r_num, n_num;
    logic                    r_neg, n_neg;
    logic [MAG_W-1:0]        r_dm, n_dm, r_rem, n_rem;
    logic [DVD_W-1:0]        r_dvd, n_dvd;
    logic [Q_W-1:0]          r_q, n_q;
    logic                    r_big, n_big;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    logic                       r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_d, n_out_d;
    t_err                       r_out_err, n_out_err;
    logic                       r_out_last, n_out_last;

    // datapath terms
    logic                     out_free;
    logic signed [DEV_W-1:0]  dev;
    logic signed [CMP_W-1:0]  dev_hi, dev_lo;
    logic                     too_far;
    logic signed [NUM_W-1:0]  i0_x, i1_x, c_x, num_first, num_center, num_last;
    logic [NUM_W-1:0]         num_abs;
    logic signed [MAG_W-1:0]  den;
    logic [MAG_W-1:0]         den_abs;
    logic [MAG_W:0]           rem_try;
    logic                     rem_ge;
    logic [Q_W-1:0]           q_lim, q_sat;
    logic                     pending;

    assign out_free = !r_out_valid || i_out_ready;

    assign dev     = DEV_W'(r_step) - DEV_W'(r_grid);
    assign dev_hi  = CMP_W'(dev) - CMP_W'(signed'({1'b0, r_tol}));
    assign dev_lo  = CMP_W'(dev) + CMP_W'(signed'({1'b0, r_tol}));
    assign too_far = (!dev_hi[CMP_W-1] && (dev_hi != '0)) || dev_lo[CMP_W-1];

    assign i0_x       = NUM_W'(r_hist1);
    assign i1_x       = NUM_W'(r_hist0);
    assign c_x        = NUM_W'(r_c);
    assign num_first  = (i1_x <<< 2) - (i0_x <<< 1) - i0_x - c_x;
    assign num_center = c_x - i0_x;
    assign num_last   = (c_x <<< 1) + c_x - (i1_x <<< 2) + i0_x;

    assign num_abs = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign den     = {r_grid, 1'b0};
    assign den_abs = den[MAG_W-1] ? MAG_W'(-den) : MAG_W'(den);

    assign rem_try = {r_rem, r_dvd[DVD_W-1]};
    assign rem_ge  = rem_try >= {1'b0, r_dm};

    assign q_lim   = r_neg ? SAT_NEG : SAT_POS;
    assign q_sat   = (r_big || (r_q > q_lim)) ? q_lim : r_q;
    assign pending = r_job_first || r_job_center || r_job_last;

    always_comb begin
        n_state      = r_state;
        n_v          = r_v;
        n_c          = r_c;
        n_end        = r_end;
        n_step       = r_step;
        n_hist0      = r_hist0;
        n_hist1      = r_hist1;
        n_prev       = r_prev;
        n_grid       = r_grid;
        n_pts        = r_pts;
        n_err        = r_err;
        n_job_first  = r_job_first;
        n_job_center = r_job_center;
        n_job_last   = r_job_last;
        n_cur_last   = r_cur_last;
        n_num        = r_num;
        n_neg        = r_neg;
        n_dm         = r_dm;
        n_rem        = r_rem;
        n_dvd        = r_dvd;
        n_q          = r_q;
        n_big        = r_big;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_d      = r_out_d;
        n_out_err    = r_out_err;
        n_out_last   = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_v     = i_voltage_sample;
                    n_c     = i_current_sample;
                    n_end   = i_sequence_end;
                    n_step  = STEP_W'(i_voltage_sample) - STEP_W'(r_prev);
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // hold until the output register can take an error request
                if (out_free) begin
                    n_state = ST_IDLE;
                    if (r_err) begin
                        if (r_end) begin
                            n_hist0 = '0; n_hist1 = '0; n_prev = '0;
                            n_grid  = '0; n_pts   = '0; n_err  = 1'b0;
                        end
                    end else if (r_pts < 2'd2 && r_end) begin
                        n_out_valid = 1'b1; n_out_d = '0;
                        n_out_err   = ERR_FEW; n_out_last = 1'b1;
                        n_hist0 = '0; n_hist1 = '0; n_prev = '0;
                        n_grid  = '0; n_pts   = '0; n_err  = 1'b0;
                    end else if (r_pts == 2'd0) begin
                        n_hist0 = r_c;
                        n_prev  = r_v;
                        n_pts   = 2'd1;
                    end else if (r_pts == 2'd1) begin
                        if (r_step == '0) begin
                            n_out_valid = 1'b1; n_out_d = '0;
                            n_out_err   = ERR_ZERO; n_out_last = 1'b1;
                            n_err       = 1'b1;
                        end else begin
                            n_grid  = r_step;
                            n_hist1 = r_hist0;
                            n_hist0 = r_c;
                            n_prev  = r_v;
                            n_pts   = 2'd2;
                        end
                    end else if (too_far) begin
                        n_out_valid = 1'b1; n_out_d = '0;
                        n_out_err   = ERR_NONUNI; n_out_last = 1'b1;
                        if (r_end) begin
                            n_hist0 = '0; n_hist1 = '0; n_prev = '0;
                            n_grid  = '0; n_pts   = '0; n_err  = 1'b0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end else begin
                        n_job_first  = (r_pts == 2'd2);
                        n_job_center = 1'b1;
                        n_job_last   = r_end;
                        n_state      = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                if (r_job_first) begin
                    n_num = num_first; n_job_first = 1'b0; n_cur_last = 1'b0;
                end else if (r_job_center) begin
                    n_num = num_center; n_job_center = 1'b0; n_cur_last = 1'b0;
                end else begin
                    n_num = num_last; n_job_last = 1'b0; n_cur_last = 1'b1;
                end
                n_state = ST_MAG;
            end
            ST_MAG: begin
                n_dvd   = {MAG_W'(num_abs), {FRAC_BITS{1'b0}}};
                n_neg   = r_num[NUM_W-1] ^ r_grid[STEP_W-1];
                n_dm    = den_abs;
                n_rem   = '0;
                n_q     = '0;
                n_big   = 1'b0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // one restoring step per cycle; bits shifted past the window stick
                n_rem = rem_ge ? MAG_W'(rem_try - {1'b0, r_dm}) : MAG_W'(rem_try);
                n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
                n_big = r_big || r_q[Q_W-1];
                n_q   = {r_q[Q_W-2:0], rem_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_d     = r_neg ? SAMPLE_W'(-q_sat) : SAMPLE_W'(q_sat);
                    n_out_err   = ERR_OK;
                    n_out_last  = r_cur_last;
                    if (pending) begin
                        n_state = ST_SETUP;
                    end else begin
                        n_state = ST_IDLE;
                        if (r_end) begin
                            n_hist0 = '0; n_hist1 = '0; n_prev = '0;
                            n_grid  = '0; n_pts   = '0; n_err  = 1'b0;
                        end else begin
                            n_hist1 = r_hist0;
                            n_hist0 = r_c;
                            n_prev  = r_v;
                            n_pts   = 2'd3;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tol        <= TOL_RESET;
            r_hist0      <= '0;
            r_hist1      <= '0;
            r_prev       <= '0;
            r_grid       <= '0;
            r_pts        <= '0;
            r_err        <= 1'b0;
            r_job_first  <= 1'b0;
            r_job_center <= 1'b0;
            r_job_last   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            r_hist0      <= n_hist0;
            r_hist1      <= n_hist1;
            r_prev       <= n_prev;
            r_grid       <= n_grid;
            r_pts        <= n_pts;
            r_err        <= n_err;
            r_job_first  <= n_job_first;
            r_job_center <= n_job_center;
            r_job_last   <= n_job_last;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_c        <= n_c;
        r_end      <= n_end;
        r_step     <= n_step;
        r_cur_last <= n_cur_last;
        r_num      <= n_num;
        r_neg      <= n_neg;
        r_dm       <= n_dm;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_q        <= n_q;
        r_big      <= n_big;
        r_cnt      <= n_cnt;
        r_out_d    <= n_out_d;
        r_out_err  <= n_out_err;
        r_out_last <= n_out_last;
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_derivative = r_out_d;
    assign o_error_code = r_out_err;
    assign o_run_last   = r_out_last;

endmodule
`default_nettype wire

// File: rtl/core/ugd_checker.sv
// Port-level checker for the grid derivative block, bound to the top level.
`default_nettype none
module ugd_checker
    import ugd_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic signed [SAMPLE_W-1:0] o_derivative,
    input wire logic [ERR_W-1:0]           o_error_code,
    input wire logic                       o_run_last
);

    // a stalled result request keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_derivative) && $stable(o_error_code)
            && $stable(o_run_last))
        else $error("result request changed while stalled");

    // error results close the run and carry no derivative
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error_code != ERR_OK) |-> o_run_last && (o_derivative == '0))
        else $error("error result not flagged last or derivative nonzero");

    // the sequencer drops input ready in the cycle after it takes a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

    // nothing shows on the output right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind uniform_grid_derivative ugd_checker u_ugd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_derivative (o_derivative),
    .o_error_code (o_error_code),
    .o_run_last   (o_run_last)
);
`default_nettype wire

// File: test/tb_uniform_grid_derivative.sv
// Self-checking testbench for uniform_grid_derivative: directed and random grid runs.
`default_nettype none
module tb_uniform_grid_derivative;
    import ugd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 200;
    localparam logic signed [SAMPLE_W-1:0] V_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] V_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_W-1:0] deriv;
        t_err                       code;
        logic                       last;
    } t_grid_result;

    logic                       i_clk            = 1'b0;
    logic                       i_rst_n          = 1'b0;
    logic                       i_cfg_wr_en      = 1'b0;
    logic [TOL_W-1:0]           i_cfg_wr_data    = '0;
    logic                       i_in_valid       = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_voltage_sample = '0;
    logic signed [SAMPLE_W-1:0] i_current_sample = '0;
    logic                       i_sequence_end   = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready      = 1'b1;
    logic signed [SAMPLE_W-1:0] o_derivative;
    logic [ERR_W-1:0]           o_error_code;
    logic                       o_run_last;

    uniform_grid_derivative dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_voltage_sample (i_voltage_sample),
        .i_current_sample (i_current_sample),
        .i_sequence_end   (i_sequence_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_derivative     (o_derivative),
        .o_error_code     (o_error_code),
        .o_run_last       (o_run_last)
    );

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_fail         = 0;

    t_grid_result derivs_due[$];

    // predictor state
    logic [TOL_W-1:0]           tol_lsb = TOL_RESET;
    logic signed [SAMPLE_W-1:0] cur_last, cur_prev, last_volt;
    logic signed [STEP_W-1:0]   step_h;
    logic [1:0]                 run_len;
    logic                       run_broken;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic restart_run();
        cur_last   = '0;
        cur_prev   = '0;
        last_volt  = '0;
        step_h     = '0;
        run_len    = '0;
        run_broken = 1'b0;
    endtask

    task automatic queue_result(input logic signed [SAMPLE_W-1:0] d, input t_err code,
                                input logic last);
        t_grid_result r;
        r.deriv = d;
        r.code  = code;
        r.last  = last;
        derivs_due.insert(derivs_due.size(), r);
    endtask

    // num * 2^FRAC_BITS / den, truncated toward zero, clamped to the sample range
    function automatic logic signed [SAMPLE_W-1:0] q16_divide(input longint num,
                                                              input longint den);
        logic            neg;
        longint unsigned nm, dm, q, lim;
        neg = (num < 0) != (den < 0);
        nm  = (num < 0) ? -num : num;
        dm  = (den < 0) ? -den : den;
        q   = (nm << FRAC_BITS) / dm;
        lim = neg ? (64'd1 << (SAMPLE_W - 1)) : (64'd1 << (SAMPLE_W - 1)) - 1;
        if (q > lim) q = lim;
        return neg ? SAMPLE_W'(-q) : SAMPLE_W'(q);
    endfunction

    task automatic compute_derivatives(input logic signed [SAMPLE_W-1:0] v_in, c_in,
                                       input logic end_in);
        longint v, c, i0, i1, pv, dev, twoh;
        v  = v_in;
        c  = c_in;
        i1 = cur_last;
        i0 = cur_prev;
        pv = last_volt;
        if (run_broken) begin
            if (end_in) restart_run();
            return;
        end
        if (run_len < 2 && end_in) begin
            queue_result('0, ERR_FEW, 1'b1);
            restart_run();
            return;
        end
        if (run_len == 0) begin
            cur_last  = c_in;
            last_volt = v_in;
            run_len   = 1;
            return;
        end
        if (run_len == 1) begin
            if (v == pv) begin
                queue_result('0, ERR_ZERO, 1'b1);
                run_broken = 1'b1;
                return;
            end
            step_h    = STEP_W'(v - pv);
            cur_prev  = cur_last;
            cur_last  = c_in;
            last_volt = v_in;
            run_len   = 2;
            return;
        end
        dev = (v - pv) - longint'(step_h);
        if (dev < 0) dev = -dev;
        if (dev > longint'(tol_lsb)) begin
            queue_result('0, ERR_NONUNI, 1'b1);
            if (end_in) restart_run();
            else run_broken = 1'b1;
            return;
        end
        twoh = 2 * longint'(step_h);
        if (run_len == 2) queue_result(q16_divide(4 * i1 - 3 * i0 - c, twoh), ERR_OK, 1'b0);
        queue_result(q16_divide(c - i0, twoh), ERR_OK, 1'b0);
        if (end_in) begin
            queue_result(q16_divide(3 * c - 4 * i1 + i0, twoh), ERR_OK, 1'b1);
            restart_run();
            return;
        end
        cur_prev  = cur_last;
        cur_last  = c_in;
        last_volt = v_in;
        run_len   = 3;
    endtask

    // valid stays high across back-to-back requests; only idle cycles drop it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, c, input logic end_in);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_voltage_sample <= v;
        i_current_sample <= c;
        i_sequence_end   <= end_in;
        do @(posedge i_clk); while (!o_in_ready);
        compute_derivatives(v, c, end_in);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (derivs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] val);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tol_lsb = val;
    endtask

    initial begin : check_results
        t_grid_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (derivs_due.size() == 0) begin
                    $error("unexpected result: derivative %0d code %0d last %0b",
                           o_derivative, o_error_code, o_run_last);
                    n_fail++;
                end else begin
                    want = derivs_due.pop_front();
                    if (o_derivative !== want.deriv) begin
                        $error("derivative: expected %0d, got %0d", want.deriv, o_derivative);
                        n_fail++;
                    end
                    if (o_error_code !== want.code) begin
                        $error("error_code: expected %0d, got %0d", want.code, o_error_code);
                        n_fail++;
                    end
                    if (o_run_last !== want.last) begin
                        $error("run_last: expected %0b, got %0b", want.last, o_run_last);
                        n_fail++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_short_runs();
        send_sample(32'sh0001_0000, 32'sh0000_0400, 1'b1);  // lone point
        send_sample('0, 5, 1'b0);
        send_sample(32'sh0001_0000, 7, 1'b1);                // two points
        send_sample(-5, 1, 1'b0);
        send_sample(-5, 2, 1'b0);                            // zero step, rest dropped
        send_sample(3, 3, 1'b1);
    endtask

    task automatic test_edge_values();
        // unit step with extreme currents: both saturation limits
        send_sample(0, V_MAX, 1'b0);
        send_sample(1, V_MIN, 1'b0);
        send_sample(2, V_MAX, 1'b1);
        // widest possible first step, then a wild one
        send_sample(V_MIN, 100, 1'b0);
        send_sample(V_MAX, 200, 1'b0);
        send_sample(0, 300, 1'b1);
        // negative step at the top of the range
        send_sample(V_MAX, V_MIN, 1'b0);
        send_sample(V_MAX - 1, V_MAX, 1'b0);
        send_sample(V_MAX - 2, 0, 1'b0);
        send_sample(V_MAX - 3, -1, 1'b1);
    endtask

    task automatic test_tolerance_bounds();
        // reset tolerance of one: deviation 1 passes, 2 breaks the run
        send_sample(0, 10, 1'b0);
        send_sample(100, 20, 1'b0);
        send_sample(201, 30, 1'b0);
        send_sample(303, 40, 1'b0);
        send_sample(400, 50, 1'b1);
        drain_results();
        write_tolerance('0);
        send_sample(0, 1, 1'b0);
        send_sample(10, 2, 1'b0);
        send_sample(21, 3, 1'b1);                            // off by one on the last point
        drain_results();
        write_tolerance('1);
        send_sample(0, 1, 1'b0);
        send_sample(100000, -2, 1'b0);
        send_sample(200000 + 65535, 3, 1'b1);
    endtask

    task automatic test_random_runs(input int send_pct, recv_pct,
                                    input logic [TOL_W-1:0] tol, input int n_items);
        int                         sent, len, kind, k;
        bit                         held;
        longint                     pv, h, jit;
        logic signed [SAMPLE_W-1:0] v, c;
        drain_results();
        write_tolerance(tol);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        held = 0;
        while (sent < n_items) begin
            if (!held && sent >= n_items / 2) begin
                drain_results();   // hold off until the pipe is empty
                held = 1;
            end
            kind = $urandom_range(99);
            len  = (kind < 10) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            h    = longint'($urandom_range(1, 1 << $urandom_range(0, 24)));
            if ($urandom_range(1)) h = -h;
            pv   = longint'($signed($urandom())) / 2;
            for (k = 0; k < len; k++) begin
                if (kind >= 95) begin
                    v = $urandom();                          // noise
                end else if (k == 0) begin
                    v = SAMPLE_W'(pv);
                end else if (k == 1) begin
                    v = (kind >= 90) ? SAMPLE_W'(pv) : SAMPLE_W'(pv + h);
                end else begin
                    if ($urandom_range(99) < 4) begin
                        jit = longint'(tol_lsb) + 1 + $urandom_range(0, 99);
                        if ($urandom_range(1)) jit = -jit;
                    end else begin
                        jit = longint'($urandom_range(0, 2 * int'(tol_lsb))) - longint'(tol_lsb);
                    end
                    v = SAMPLE_W'(pv + h + jit);
                end
                pv = v;
                if ($urandom_range(99) < 20) c = $urandom();
                else c = $signed($urandom()) >>> 11;
                send_sample(v, c, k == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        restart_run();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_runs();
        test_edge_values();
        test_tolerance_bounds();
        test_random_runs(0, 0, TOL_RESET, 125);
        test_random_runs(70, 0, '1, 125);
        test_random_runs(0, 70, '0, 125);
        test_random_runs(16, 16, TOL_W'($urandom_range(2, 4000)), 125);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("[uniform_grid_derivative] OK");
        end else begin
            $display("[uniform_grid_derivative] ERROR");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("[uniform_grid_derivative] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
